>>> src/waitrim_pkg.sv
// Shared types, constants and helper functions for the windowed alignment
// identity trimmer. No dependencies; used by waitrim_div and the top level.
package waitrim_pkg;

   localparam int POS_BITS_DEF = 24;

   localparam int FIELD_W = 24;
   localparam int CNT_W   = 24;
   localparam int SUM_W   = 48;
   localparam int ID_W    = 17;
   localparam int WS_W    = 10;
   localparam int COV_W   = 7;
   localparam int SPAN_W  = 26;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [ID_W-1:0]  Q_ONE   = 17'd65536;
   localparam logic [COV_W-1:0] COV_MAX = 7'd100;

   localparam logic [WS_W-1:0] WINDOW_SIZE_RESET  = 10'd30;
   localparam logic [ID_W-1:0] MIN_IDENTITY_RESET = 17'd52429;

   // Register indexes on the csr port.
   localparam logic CSR_WINDOW_SIZE  = 1'b0;
   localparam logic CSR_MIN_IDENTITY = 1'b1;

   // Transaction actions and edit operations.
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_OP    = 2'd1;
   localparam logic [1:0] ACT_END   = 2'd2;

   localparam logic [1:0] OP_MATCH  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_SUBST  = 2'd3;

   // Shared divider geometry: dividend is left aligned, nbits steps are run.
   localparam int DIV_DW = 48;
   localparam int DIV_SW = 26;
   localparam int DIV_CW = 6;

   localparam logic [DIV_CW-1:0] NB_PHASE = DIV_CW'(24);
   localparam logic [DIV_CW-1:0] NB_IDEN  = DIV_CW'(40);
   localparam logic [DIV_CW-1:0] NB_MEAN  = DIV_CW'(48);
   localparam logic [DIV_CW-1:0] NB_COV   = DIV_CW'(31);

   typedef struct packed {
      logic              start;
      logic [DIV_DW-1:0] dividend;
      logic [DIV_SW-1:0] divisor;
      logic [DIV_CW-1:0] nbits;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DIV_DW-1:0] quotient;
      logic [DIV_SW-1:0] remainder;
   } div_rsp_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
   endfunction

   function automatic logic [CNT_W-1:0] sat_add_cnt(input logic [CNT_W-1:0] a,
                                                    input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
   endfunction

   function automatic logic [SUM_W-1:0] sat_add_sum(input logic [SUM_W-1:0] a,
                                                    input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
   endfunction

endpackage

>>> src/waitrim_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, shared by every
// division of the trimmer. Depends on waitrim_pkg.
module waitrim_div import waitrim_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_DW-1:0] dvd_ff;
   logic [DIV_SW-1:0] dsr_ff;
   logic [DIV_SW-1:0] rem_ff;
   logic [DIV_DW-1:0] quo_ff;

   logic [DIV_SW:0] trial;
   logic [DIV_SW:0] diff;
   logic            fits;

   assign trial = {rem_ff, dvd_ff[DIV_DW-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.nbits;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - DIV_CW'(1);
         if (cnt_ff == DIV_CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         dvd_ff <= div_req.dividend;
         dsr_ff <= div_req.divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DIV_DW-2:0], 1'b0};
         rem_ff <= fits ? diff[DIV_SW-1:0] : trial[DIV_SW-1:0];
         quo_ff <= {quo_ff[DIV_DW-2:0], fits};
      end
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

>>> src/windowed_alignment_identity_trim_top.sv
// Top level of the windowed alignment identity trimmer: window bookkeeping,
// sequencer and result register. Depends on waitrim_pkg and waitrim_div.
//
// Usage: one alignment is a start transaction (target start, query length),
// a stream of operation transactions (match, insertion, deletion,
// substitution) and an end transaction, which produces one result on the
// rsp channel. Both channels use valid/stall; csr writes window_size
// (index 0) and min_identity (index 1) and is always ready.
// Sequencing: an operation that does not close a window needs no division.
// A start runs the shared divider for the window phase (24 quotient bits).
// An operation that closes a window runs a 40-bit division for the window
// identity, plus a merge step (S_KEEP) when a good window is merged.
// An end closes the last window if one is open, then runs the 48-bit mean
// division and the 31-bit coverage division when a good window was found.
// All divisions go through the single serial divider; req_stall is high
// while a transaction is in work.
// A finished result waits in the output register; when the receiver stalls
// rsp, the block keeps taking start and operation transactions and only
// holds a following end transaction before its result register load.
// Reset (synchronous, active high) clears positions, counts and sums and
// restores window_size 30 and min_identity 0.8.
module windowed_alignment_identity_trim_top import waitrim_pkg::*; #(
   parameter int POS_BITS = POS_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic [1:0]          req_op_code,
   input  logic [FIELD_W-1:0]  req_target_start,
   input  logic [FIELD_W-1:0]  req_query_length,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_found,
   output logic [FIELD_W-1:0]  rsp_trim_target_start,
   output logic [FIELD_W-1:0]  rsp_trim_target_stop,
   output logic [FIELD_W-1:0]  rsp_trim_query_start,
   output logic [FIELD_W-1:0]  rsp_trim_query_stop,
   output logic [ID_W-1:0]     rsp_mean_identity,
   output logic [COV_W-1:0]    rsp_query_coverage,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [ID_W-1:0]     csr_wdata
);

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_PHASE      = 4'd1;
   localparam logic [3:0] S_CLOSE      = 4'd2;
   localparam logic [3:0] S_CLOSE_WAIT = 4'd3;
   localparam logic [3:0] S_KEEP       = 4'd4;
   localparam logic [3:0] S_MEAN       = 4'd5;
   localparam logic [3:0] S_MEAN_WAIT  = 4'd6;
   localparam logic [3:0] S_COV        = 4'd7;
   localparam logic [3:0] S_COV_WAIT   = 4'd8;
   localparam logic [3:0] S_OUT        = 4'd9;

   // Positions are reported through their low field bits.
   function automatic logic [FIELD_W-1:0] pos_field(input logic [POS_BITS-1:0] v);
      logic [31:0] ext;
      ext = 32'(v);
      return ext[FIELD_W-1:0];
   endfunction

   logic [3:0]          state_ff, state_in;
   logic                end_pend_ff, end_pend_in;
   logic [WS_W-1:0]     window_size_ff;
   logic [ID_W-1:0]     min_identity_ff;

   logic [POS_BITS-1:0] query_pos_ff, query_pos_in;
   logic [POS_BITS-1:0] target_pos_ff, target_pos_in;
   logic [WS_W-1:0]     target_phase_ff, target_phase_in;
   logic [CNT_W-1:0]    match_cnt_ff, match_cnt_in;
   logic [CNT_W-1:0]    insert_cnt_ff, insert_cnt_in;
   logic [CNT_W-1:0]    delete_cnt_ff, delete_cnt_in;
   logic [CNT_W-1:0]    subst_cnt_ff, subst_cnt_in;
   logic                seen_good_ff, seen_good_in;
   logic [FIELD_W-1:0]  first_t_ff, first_t_in;
   logic [FIELD_W-1:0]  first_q_ff, first_q_in;
   logic [FIELD_W-1:0]  last_t_ff, last_t_in;
   logic [FIELD_W-1:0]  last_q_ff, last_q_in;
   logic [SUM_W-1:0]    pend_sum_ff, pend_sum_in;
   logic [CNT_W-1:0]    pend_cnt_ff, pend_cnt_in;
   logic [SUM_W-1:0]    kept_sum_ff, kept_sum_in;
   logic [CNT_W-1:0]    kept_cnt_ff, kept_cnt_in;
   logic [FIELD_W-1:0]  held_qlen_ff, held_qlen_in;
   logic [FIELD_W-1:0]  span_ff, span_in;
   logic [ID_W-1:0]     mean_ff, mean_in;
   logic [COV_W-1:0]    cov_ff, cov_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_load;
   logic                rsp_found_ff;
   logic [FIELD_W-1:0]  rsp_tstart_ff, rsp_tstop_ff, rsp_qstart_ff, rsp_qstop_ff;
   logic [ID_W-1:0]     rsp_mean_ff;
   logic [COV_W-1:0]    rsp_cov_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic                req_take;
   logic                out_free;
   logic [WS_W-1:0]     win_eff;
   logic [WS_W:0]       phase_inc;
   logic [SPAN_W-1:0]   d_aln, d_tgt, d_qry;
   logic [POS_BITS-1:0] win_tstart, win_qstart;
   logic [ID_W-1:0]     iden;
   logic                good;
   logic [30:0]         cov_prod;
   logic [CNT_W-1:0]    m_nx, i_nx, d_nx, s_nx;

   waitrim_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign win_eff   = (window_size_ff == '0) ? WS_W'(1) : window_size_ff;
   assign phase_inc = {1'b0, target_phase_ff} + (WS_W+1)'(1);

   assign d_aln = {2'b0, match_cnt_ff} + {2'b0, insert_cnt_ff}
                + {2'b0, delete_cnt_ff} + {2'b0, subst_cnt_ff};
   assign d_tgt = {2'b0, match_cnt_ff} + {2'b0, delete_cnt_ff} + {2'b0, subst_cnt_ff};
   assign d_qry = {2'b0, match_cnt_ff} + {2'b0, insert_cnt_ff} + {2'b0, subst_cnt_ff};
   assign win_tstart = target_pos_ff - POS_BITS'(d_tgt);
   assign win_qstart = query_pos_ff - POS_BITS'(d_qry);

   // The identity quotient never exceeds one, so its low bits are exact, and
   // floor(identity) >= threshold is the same test as m*65536 >= thr*aln.
   assign iden = div_rsp.quotient[ID_W-1:0];
   assign good = (iden >= min_identity_ff);

   assign cov_prod = ({7'b0, span_ff} << 6) + ({7'b0, span_ff} << 5)
                   + ({7'b0, span_ff} << 2);

   always_comb begin
      state_in        = state_ff;
      end_pend_in     = end_pend_ff;
      query_pos_in    = query_pos_ff;
      target_pos_in   = target_pos_ff;
      target_phase_in = target_phase_ff;
      match_cnt_in    = match_cnt_ff;
      insert_cnt_in   = insert_cnt_ff;
      delete_cnt_in   = delete_cnt_ff;
      subst_cnt_in    = subst_cnt_ff;
      seen_good_in    = seen_good_ff;
      first_t_in      = first_t_ff;
      first_q_in      = first_q_ff;
      last_t_in       = last_t_ff;
      last_q_in       = last_q_ff;
      pend_sum_in     = pend_sum_ff;
      pend_cnt_in     = pend_cnt_ff;
      kept_sum_in     = kept_sum_ff;
      kept_cnt_in     = kept_cnt_ff;
      held_qlen_in    = held_qlen_ff;
      span_in         = span_ff;
      mean_in         = mean_ff;
      cov_in          = cov_ff;
      rsp_load        = 1'b0;
      m_nx            = match_cnt_ff;
      i_nx            = insert_cnt_ff;
      d_nx            = delete_cnt_ff;
      s_nx            = subst_cnt_ff;
      div_req         = '{start: 1'b0, dividend: '0, divisor: '0, nbits: '0};

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_action)
                  ACT_START: begin
                     target_pos_in = POS_BITS'(req_target_start);
                     query_pos_in  = '0;
                     held_qlen_in  = req_query_length;
                     match_cnt_in  = '0;
                     insert_cnt_in = '0;
                     delete_cnt_in = '0;
                     subst_cnt_in  = '0;
                     seen_good_in  = 1'b0;
                     first_t_in    = '0;
                     first_q_in    = '0;
                     last_t_in     = '0;
                     last_q_in     = '0;
                     pend_sum_in   = '0;
                     pend_cnt_in   = '0;
                     kept_sum_in   = '0;
                     kept_cnt_in   = '0;
                     div_req.start    = 1'b1;
                     div_req.dividend = {req_target_start, {(DIV_DW-FIELD_W){1'b0}}};
                     div_req.divisor  = DIV_SW'(win_eff);
                     div_req.nbits    = NB_PHASE;
                     state_in = S_PHASE;
                  end
                  ACT_OP: begin
                     case (req_op_code)
                        OP_MATCH:  m_nx = sat_inc(match_cnt_ff);
                        OP_INSERT: i_nx = sat_inc(insert_cnt_ff);
                        OP_DELETE: d_nx = sat_inc(delete_cnt_ff);
                        default:   s_nx = sat_inc(subst_cnt_ff);
                     endcase
                     match_cnt_in  = m_nx;
                     insert_cnt_in = i_nx;
                     delete_cnt_in = d_nx;
                     subst_cnt_in  = s_nx;
                     if (req_op_code != OP_DELETE) begin
                        query_pos_in = query_pos_ff + POS_BITS'(1);
                     end
                     if (req_op_code != OP_INSERT) begin
                        target_pos_in = target_pos_ff + POS_BITS'(1);
                        target_phase_in = (phase_inc >= {1'b0, win_eff}) ? '0
                                        : phase_inc[WS_W-1:0];
                     end
                     if (target_phase_in == '0 && (m_nx | d_nx | s_nx) != '0) begin
                        end_pend_in = 1'b0;
                        state_in    = S_CLOSE;
                     end
                  end
                  ACT_END: begin
                     end_pend_in = 1'b1;
                     if ((match_cnt_ff | delete_cnt_ff | subst_cnt_ff) != '0) begin
                        state_in = S_CLOSE;
                     end else begin
                        state_in = S_MEAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PHASE: begin
            if (div_rsp.done) begin
               target_phase_in = div_rsp.remainder[WS_W-1:0];
               state_in = S_IDLE;
            end
         end
         S_CLOSE: begin
            div_req.start    = 1'b1;
            div_req.dividend = {match_cnt_ff, {(DIV_DW-CNT_W){1'b0}}};
            div_req.divisor  = d_aln;
            div_req.nbits    = NB_IDEN;
            state_in = S_CLOSE_WAIT;
         end
         S_CLOSE_WAIT: begin
            if (div_rsp.done) begin
               match_cnt_in  = '0;
               insert_cnt_in = '0;
               delete_cnt_in = '0;
               subst_cnt_in  = '0;
               state_in = end_pend_ff ? S_MEAN : S_IDLE;
               if (good) begin
                  last_t_in = pos_field(target_pos_ff);
                  last_q_in = pos_field(query_pos_ff);
               end
               if (good && !seen_good_ff) begin
                  seen_good_in = 1'b1;
                  first_t_in   = pos_field(win_tstart);
                  first_q_in   = pos_field(win_qstart);
                  kept_sum_in  = SUM_W'(iden);
                  kept_cnt_in  = CNT_W'(1);
                  pend_sum_in  = '0;
                  pend_cnt_in  = '0;
               end else if (seen_good_ff) begin
                  // A good window folds this window and the bad ones before it
                  // into the kept totals on the next cycle.
                  pend_sum_in = sat_add_sum(pend_sum_ff, SUM_W'(iden));
                  pend_cnt_in = sat_inc(pend_cnt_ff);
                  if (good) begin
                     state_in = S_KEEP;
                  end
               end
            end
         end
         S_KEEP: begin
            kept_sum_in = sat_add_sum(kept_sum_ff, pend_sum_ff);
            kept_cnt_in = sat_add_cnt(kept_cnt_ff, pend_cnt_ff);
            pend_sum_in = '0;
            pend_cnt_in = '0;
            state_in = end_pend_ff ? S_MEAN : S_IDLE;
         end
         S_MEAN: begin
            span_in = (last_q_ff >= first_q_ff) ? last_q_ff - first_q_ff
                                                : first_q_ff - last_q_ff;
            if (seen_good_ff && kept_cnt_ff != '0) begin
               div_req.start    = 1'b1;
               div_req.dividend = kept_sum_ff;
               div_req.divisor  = DIV_SW'(kept_cnt_ff);
               div_req.nbits    = NB_MEAN;
               state_in = S_MEAN_WAIT;
            end else begin
               mean_in  = '0;
               state_in = S_COV;
            end
         end
         S_MEAN_WAIT: begin
            if (div_rsp.done) begin
               mean_in = (div_rsp.quotient > DIV_DW'(Q_ONE)) ? Q_ONE
                       : div_rsp.quotient[ID_W-1:0];
               state_in = S_COV;
            end
         end
         S_COV: begin
            if (seen_good_ff && held_qlen_ff != '0) begin
               div_req.start    = 1'b1;
               div_req.dividend = {cov_prod, {(DIV_DW-31){1'b0}}};
               div_req.divisor  = DIV_SW'(held_qlen_ff);
               div_req.nbits    = NB_COV;
               state_in = S_COV_WAIT;
            end else begin
               cov_in   = '0;
               state_in = S_OUT;
            end
         end
         S_COV_WAIT: begin
            if (div_rsp.done) begin
               cov_in = (div_rsp.quotient > DIV_DW'(COV_MAX)) ? COV_MAX
                      : div_rsp.quotient[COV_W-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               match_cnt_in  = '0;
               insert_cnt_in = '0;
               delete_cnt_in = '0;
               subst_cnt_in  = '0;
               seen_good_in  = 1'b0;
               first_t_in    = '0;
               first_q_in    = '0;
               last_t_in     = '0;
               last_q_in     = '0;
               pend_sum_in   = '0;
               pend_cnt_in   = '0;
               kept_sum_in   = '0;
               kept_cnt_in   = '0;
               end_pend_in   = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         end_pend_ff     <= 1'b0;
         window_size_ff  <= WINDOW_SIZE_RESET;
         min_identity_ff <= MIN_IDENTITY_RESET;
         query_pos_ff    <= '0;
         target_pos_ff   <= '0;
         target_phase_ff <= '0;
         match_cnt_ff    <= '0;
         insert_cnt_ff   <= '0;
         delete_cnt_ff   <= '0;
         subst_cnt_ff    <= '0;
         seen_good_ff    <= 1'b0;
         first_t_ff      <= '0;
         first_q_ff      <= '0;
         last_t_ff       <= '0;
         last_q_ff       <= '0;
         pend_sum_ff     <= '0;
         pend_cnt_ff     <= '0;
         kept_sum_ff     <= '0;
         kept_cnt_ff     <= '0;
         held_qlen_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         end_pend_ff     <= end_pend_in;
         query_pos_ff    <= query_pos_in;
         target_pos_ff   <= target_pos_in;
         target_phase_ff <= target_phase_in;
         match_cnt_ff    <= match_cnt_in;
         insert_cnt_ff   <= insert_cnt_in;
         delete_cnt_ff   <= delete_cnt_in;
         subst_cnt_ff    <= subst_cnt_in;
         seen_good_ff    <= seen_good_in;
         first_t_ff      <= first_t_in;
         first_q_ff      <= first_q_in;
         last_t_ff       <= last_t_in;
         last_q_ff       <= last_q_in;
         pend_sum_ff     <= pend_sum_in;
         pend_cnt_ff     <= pend_cnt_in;
         kept_sum_ff     <= kept_sum_in;
         kept_cnt_ff     <= kept_cnt_in;
         held_qlen_ff    <= held_qlen_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_SIZE:  window_size_ff  <= csr_wdata[WS_W-1:0];
               CSR_MIN_IDENTITY: min_identity_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Working values and the result payload need no reset.
   always_ff @(posedge clock) begin
      span_ff <= span_in;
      mean_ff <= mean_in;
      cov_ff  <= cov_in;
      if (rsp_load) begin
         rsp_found_ff  <= seen_good_ff;
         rsp_tstart_ff <= seen_good_ff ? first_t_ff : '0;
         rsp_tstop_ff  <= seen_good_ff ? last_t_ff : '0;
         rsp_qstart_ff <= seen_good_ff ? first_q_ff : '0;
         rsp_qstop_ff  <= seen_good_ff ? last_q_ff : '0;
         rsp_mean_ff   <= mean_ff;
         rsp_cov_ff    <= cov_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_found             = rsp_found_ff;
   assign rsp_trim_target_start = rsp_tstart_ff;
   assign rsp_trim_target_stop  = rsp_tstop_ff;
   assign rsp_trim_query_start  = rsp_qstart_ff;
   assign rsp_trim_query_stop   = rsp_qstop_ff;
   assign rsp_mean_identity     = rsp_mean_ff;
   assign rsp_query_coverage    = rsp_cov_ff;

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider restarted while busy");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUT))
      else $error("result raised outside the output step");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mean_identity <= Q_ONE && rsp_query_coverage <= COV_MAX))
      else $error("result field out of range");

   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> (!seen_good_ff && kept_cnt_ff == '0
                                           && state_ff == S_IDLE))
      else $error("alignment totals not cleared after end transaction");

endmodule
